>>> hdl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants shared by the start-of-frame deframer modules.
// ----------------------------------------------------------------------------
package sfd_pkg;

    typedef enum logic [2:0] {
        ST_SOF1 = 3'd0,
        ST_SOF2 = 3'd1,
        ST_KIND = 3'd2,
        ST_SKIP = 3'd3,
        ST_DATA = 3'd4,
        ST_CR   = 3'd5,
        ST_LF   = 3'd6
    } state_t;

    typedef enum logic {
        REG_SOF_FIRST  = 1'b0,
        REG_SOF_SECOND = 1'b1
    } reg_index_t;

    localparam logic [7:0] CHAR_CLOSE = 8'h5D;  // ']'
    localparam logic [7:0] CHAR_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef struct packed {
        logic [7:0] sof_first_byte;
        logic [7:0] sof_second_byte;
    } cfg_t;

    typedef struct packed {
        logic       byte_valid;
        logic [5:0] byte_index;
        logic [7:0] payload_byte;
        logic       byte_dropped;
        logic       frame_done;
        logic [7:0] frame_kind;
    } result_t;

endpackage

>>> hdl/sfd_apb_regs.sv
// ----------------------------------------------------------------------------
// sfd_apb_regs
// APB register file holding the two start-of-frame byte values.
// ----------------------------------------------------------------------------
module sfd_apb_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sfd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sfd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sfd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output sfd_pkg::cfg_t                     cfg
);

    logic [7:0]          sof_first_reg;
    logic [7:0]          sof_second_reg;
    logic                wr_en;
    sfd_pkg::reg_index_t reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = sfd_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sof_first_reg  <= 8'h00;
            sof_second_reg <= 8'h00;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                sfd_pkg::REG_SOF_FIRST:  sof_first_reg  <= pwdata[7:0];
                sfd_pkg::REG_SOF_SECOND: sof_second_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            sfd_pkg::REG_SOF_FIRST:  prdata[7:0] = sof_first_reg;
            sfd_pkg::REG_SOF_SECOND: prdata[7:0] = sof_second_reg;
            default:                 prdata      = '0;
        endcase
    end

    assign cfg.sof_first_byte  = sof_first_reg;
    assign cfg.sof_second_byte = sof_second_reg;

endmodule

>>> hdl/sfd_parser.sv
// ----------------------------------------------------------------------------
// sfd_parser
// Input word register and frame state machine; one result per byte.
// ----------------------------------------------------------------------------
module sfd_parser
#(
    parameter int PAYLOAD_CAPACITY = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  sfd_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    output logic             res_valid,
    input  logic             res_ready,
    output sfd_pkg::result_t res
);

    localparam int CNT_W = $clog2(PAYLOAD_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(PAYLOAD_CAPACITY);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              fire;

    sfd_pkg::state_t   state_reg;
    sfd_pkg::state_t   state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [7:0]        kind_reg;
    logic [7:0]        kind_next;

    assign fire      = in_valid_reg && res_ready;
    assign in_ready  = !in_valid_reg || res_ready;
    assign res_valid = in_valid_reg;

    always_comb
    begin
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= rx_byte;
    end

    // next state
    always_comb
    begin
        state_next = sfd_pkg::ST_SOF1;
        unique case (state_reg)
            sfd_pkg::ST_SOF1:
                state_next = (in_byte_reg == cfg.sof_first_byte) ?
                             sfd_pkg::ST_SOF2 : sfd_pkg::ST_SOF1;
            sfd_pkg::ST_SOF2:
                state_next = (in_byte_reg == cfg.sof_second_byte) ?
                             sfd_pkg::ST_KIND : sfd_pkg::ST_SOF1;
            sfd_pkg::ST_KIND:
                state_next = sfd_pkg::ST_SKIP;
            sfd_pkg::ST_SKIP:
                state_next = sfd_pkg::ST_DATA;
            sfd_pkg::ST_DATA:
                state_next = (in_byte_reg == sfd_pkg::CHAR_CLOSE) ?
                             sfd_pkg::ST_CR : sfd_pkg::ST_DATA;
            sfd_pkg::ST_CR:
                state_next = (in_byte_reg == sfd_pkg::CHAR_CR) ?
                             sfd_pkg::ST_LF : sfd_pkg::ST_SOF1;
            sfd_pkg::ST_LF:
                state_next = sfd_pkg::ST_SOF1;
            default:
                state_next = sfd_pkg::ST_SOF1;
        endcase
    end

    // outputs, count and kind
    always_comb
    begin
        res            = '0;
        count_next     = count_reg;
        kind_next      = kind_reg;
        unique case (state_reg)
            sfd_pkg::ST_KIND:
                kind_next = in_byte_reg;
            sfd_pkg::ST_DATA:
            begin
                if (in_byte_reg == sfd_pkg::CHAR_CLOSE)
                    count_next = '0;
                else if (in_byte_reg != sfd_pkg::CHAR_COMMA)
                begin
                    if (count_reg < CAP)
                    begin
                        res.byte_valid   = 1'b1;
                        res.byte_index   = 6'(count_reg);
                        res.payload_byte = in_byte_reg;
                        count_next       = count_reg + 1'b1;
                    end
                    else
                        res.byte_dropped = 1'b1;
                end
            end
            sfd_pkg::ST_LF:
                res.frame_done = (in_byte_reg == sfd_pkg::CHAR_LF);
            default: ;
        endcase
        res.frame_kind = kind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfd_pkg::ST_SOF1;
            count_reg <= '0;
            kind_reg  <= 8'h00;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            kind_reg  <= kind_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("payload count above capacity");

    a_store_or_drop: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(res.byte_valid && res.byte_dropped))
        else $error("byte both stored and dropped");

    a_kind_latch: assert property (@(posedge clk) disable iff (!rst_n)
        fire && state_reg == sfd_pkg::ST_KIND |=> kind_reg == $past(in_byte_reg))
        else $error("kind byte not latched");

    a_done_from_lf: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.frame_done |=> state_reg == sfd_pkg::ST_SOF1)
        else $error("frame done without return to hunt");

endmodule

>>> hdl/sfd_out_stage.sv
// ----------------------------------------------------------------------------
// sfd_out_stage
// Result register between the parser and the output channel.
// ----------------------------------------------------------------------------
module sfd_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    output logic             res_ready,
    input  sfd_pkg::result_t res,
    output logic             out_valid,
    input  logic             out_ready,
    output sfd_pkg::result_t out_res
);

    logic             valid_reg;
    logic             valid_next;
    sfd_pkg::result_t data_reg;

    assign res_ready = !valid_reg || out_ready;

    always_comb
    begin
        if (res_valid && res_ready)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            data_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

endmodule

>>> hdl/sof_framed_packet_deframer.sv
// ----------------------------------------------------------------------------
// sof_framed_packet_deframer
// Byte stream deframer: start-of-frame hunt, kind byte, payload, CR LF trailer.
//
//   channel | handshake              | words
//   --------+------------------------+-------------------------------------
//   input   | in_valid / in_ready    | rx_byte
//   output  | out_valid / out_ready  | byte_valid, byte_index, payload_byte,
//           |                        | byte_dropped, frame_done, frame_kind
//   config  | APB psel/penable/...   | sof_first_byte @0, sof_second_byte @4
//
// One word in, one word out; a word is taken every cycle while the output is not stalled.
// Each word passes through two registers: the input register, then the result register.
// Output stalls back up through both registers; no word is lost.
// Reset puts the parser in the hunt for the first start byte.
// ----------------------------------------------------------------------------
module sof_framed_packet_deframer
#(
    parameter int PAYLOAD_CAPACITY = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sfd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sfd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           byte_valid,
    output logic [5:0]                     byte_index,
    output logic [7:0]                     payload_byte,
    output logic                           byte_dropped,
    output logic                           frame_done,
    output logic [7:0]                     frame_kind
);

    sfd_pkg::cfg_t    cfg;
    sfd_pkg::result_t res;
    sfd_pkg::result_t out_res;
    logic             res_valid;
    logic             res_ready;

    sfd_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfd_parser #(
        .PAYLOAD_CAPACITY (PAYLOAD_CAPACITY)
    ) u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    sfd_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign byte_valid   = out_res.byte_valid;
    assign byte_index   = out_res.byte_index;
    assign payload_byte = out_res.payload_byte;
    assign byte_dropped = out_res.byte_dropped;
    assign frame_done   = out_res.frame_done;
    assign frame_kind   = out_res.frame_kind;

endmodule
